[rtl/core/fbfl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfl_pkg
// Shared types and codes for the fixed block free list allocator.
// ----------------------------------------------------------------------------
package fbfl_pkg;

    localparam int DEF_BLOCK_COUNT = 32;

    localparam int IDX_W    = 5;
    localparam int CNT_W    = 6;
    localparam int STATUS_W = 2;

    // operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] STS_ALLOCATED = 2'd0;
    localparam logic [STATUS_W-1:0] STS_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] STS_FREED     = 2'd2;

    typedef struct packed {
        logic             operation;
        logic [IDX_W-1:0] block_index;
    } t_alloc_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    granted_index;
        logic [CNT_W-1:0]    free_count;
        logic [CNT_W-1:0]    used_count;
    } t_alloc_rsp;

    typedef enum logic [1:0] {
        FSM_INIT,
        FSM_IDLE,
        FSM_POP
    } t_fsm_state;

endpackage

[rtl/core/fixed_block_free_list_allocator_unit.sv]
`timescale 1ns / 1ps
// Allocate from a non-empty pool passes through POP between input beat and
//   result register (the link read from the RAM, then the head update).
//   Free and empty-pool allocate write the result register directly.
// Throughput: a granting allocate holds off new beats while in POP; one item per
//   cycle for free and empty-pool allocate while the result side keeps draining.
// Reset: synchronous active low; afterwards the INIT state walks every entry and
//   writes the initial chain into the link RAM, and no beat is taken meanwhile.
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator_unit
// Pool allocator: free list of block indices held in a link RAM, head and
// free counter in registers.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator_unit #(
    parameter int BLOCK_COUNT = fbfl_pkg::DEF_BLOCK_COUNT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  fbfl_pkg::t_alloc_req i_in_req,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output fbfl_pkg::t_alloc_rsp o_out_rsp
);

    import fbfl_pkg::*;

    // link values run 0..BLOCK_COUNT, BLOCK_COUNT meaning "none"
    localparam int LW = $clog2(BLOCK_COUNT + 1);
    localparam int AW = $clog2(BLOCK_COUNT);
    localparam logic [LW-1:0] LINK_NONE = LW'(BLOCK_COUNT);
    localparam logic [AW-1:0] LAST_IDX  = AW'(BLOCK_COUNT - 1);

    t_fsm_state r_state, n_state;
    logic [LW-1:0] r_head, n_head;
    logic [LW-1:0] r_free, n_free;
    logic [AW-1:0] r_init_idx, n_init_idx;
    logic          r_out_valid, n_out_valid;
    t_alloc_rsp    r_rsp, n_rsp;

    logic          accept;
    logic          out_free;
    logic          free_in_range;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [LW-1:0] ram_wdata;
    logic [LW-1:0] ram_rdata;

    // link RAM; read port always points at the current head
    fbfl_ram #(
        .WIDTH(LW),
        .DEPTH(BLOCK_COUNT)
    ) u_link_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(AW'(r_head)),
        .o_rdata(ram_rdata)
    );

    // result slot is usable if empty or drained this cycle
    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == FSM_IDLE) && out_free;
    assign accept     = i_in_valid && o_in_ready;

    assign free_in_range = 32'(i_in_req.block_index) < 32'(BLOCK_COUNT);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            FSM_INIT: begin
                if (r_init_idx == LAST_IDX) begin
                    n_state = FSM_IDLE;
                end
            end
            FSM_IDLE: begin
                // pop of a non-empty list goes through POP to wait for the link read
                if (accept && i_in_req.operation == OP_ALLOC && r_head < LINK_NONE) begin
                    n_state = FSM_POP;
                end
            end
            FSM_POP: begin
                n_state = FSM_IDLE;
            end
            default: begin
                n_state = FSM_INIT;
            end
        endcase
    end

    // datapath and RAM control
    always_comb begin
        n_head      = r_head;
        n_free      = r_free;
        n_init_idx  = r_init_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        n_rsp       = r_rsp;
        ram_we      = 1'b0;
        ram_waddr   = AW'(i_in_req.block_index);
        ram_wdata   = r_head;

        case (r_state)
            FSM_INIT: begin
                // initial chain: entry i links i+1, last links none
                ram_we     = 1'b1;
                ram_waddr  = r_init_idx;
                ram_wdata  = LW'(r_init_idx) + LW'(1);
                n_init_idx = r_init_idx + AW'(1);
            end
            FSM_IDLE: begin
                if (accept) begin
                    if (i_in_req.operation == OP_FREE) begin
                        if (free_in_range) begin
                            ram_we = 1'b1;
                            n_head = LW'(i_in_req.block_index);
                            if (r_free < LINK_NONE) begin
                                n_free = r_free + LW'(1);
                            end
                        end
                        n_out_valid         = 1'b1;
                        n_rsp.status        = STS_FREED;
                        n_rsp.granted_index = i_in_req.block_index;
                        n_rsp.free_count    = CNT_W'(n_free);
                        n_rsp.used_count    = CNT_W'(LINK_NONE - n_free);
                    end else if (r_head >= LINK_NONE) begin
                        n_out_valid         = 1'b1;
                        n_rsp.status        = STS_EMPTY;
                        n_rsp.granted_index = '0;
                        n_rsp.free_count    = CNT_W'(r_free);
                        n_rsp.used_count    = CNT_W'(LINK_NONE - r_free);
                    end
                end
            end
            FSM_POP: begin
                // link of the old head is on the read port now
                n_head = ram_rdata;
                if (r_free != '0) begin
                    n_free = r_free - LW'(1);
                end
                n_out_valid         = 1'b1;
                n_rsp.status        = STS_ALLOCATED;
                n_rsp.granted_index = IDX_W'(r_head);
                n_rsp.free_count    = CNT_W'(n_free);
                n_rsp.used_count    = CNT_W'(LINK_NONE - n_free);
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= FSM_INIT;
            r_head      <= '0;
            r_free      <= LINK_NONE;
            r_init_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_free      <= n_free;
            r_init_idx  <= n_init_idx;
            r_out_valid <= n_out_valid;
        end
        r_rsp <= n_rsp;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_rsp;

endmodule

[rtl/core/fbfl_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfl_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fbfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
